FILE: rtl/crfe_pkg.sv
// Shared constants and types for the clipped rectangle fill engine.
`default_nettype none

package crfe_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int STORE_BYTES   = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int ADDR_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int COORD_W = $clog2(((SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                   SCREEN_WIDTH : SCREEN_HEIGHT) + 1);
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 16;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_RECT  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLIP,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/clipped_rect_fill_engine.sv
// Top level: command sequencer and frame store of the clipped rectangle fill engine.
//
//   channel   dir  handshake                     words
//   command   in   in_valid_i / in_stall_o       operation, left, top, size, color
//   result    out  out_valid_o / out_stall_i     pixels_written
//   config    in   cfg_we_i                      enabled bit
//
// A command is captured, then clipped, then writes one clipped pixel per cycle,
// then posts its result; a command that clips to nothing skips the fill.
// The single write port of the frame store sets the fill rate: one pixel a cycle.
// The frame store holds no reset value; only control registers are cleared.
// A stalled result holds the engine in its final state; a new command is taken
// as soon as the result register is loaded, even while that result still waits.
`default_nettype none

module clipped_rect_fill_engine (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           operation_i,
  input  wire logic signed [crfe_pkg::FIELD_W-1:0]  left_i,
  input  wire logic signed [crfe_pkg::FIELD_W-1:0]  top_i,
  input  wire logic signed [crfe_pkg::FIELD_W-1:0]  rect_width_i,
  input  wire logic signed [crfe_pkg::FIELD_W-1:0]  rect_height_i,
  input  wire logic [7:0]                           fill_color_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [crfe_pkg::COUNT_W-1:0]              pixels_written_o
);
  import crfe_pkg::*;

  localparam int SUM_W = FIELD_W + 1;
  localparam logic [ADDR_W-1:0]  WIDTH_A  = ADDR_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] WIDTH_C  = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0] HEIGHT_C = COORD_W'(SCREEN_HEIGHT);

  // clamp a coordinate to [0, hi]
  function automatic logic [COORD_W-1:0] clamp_c(logic signed [SUM_W-1:0] v,
                                                 logic [COORD_W-1:0] hi);
    logic signed [SUM_W-1:0] hs;
    hs = $signed(SUM_W'(hi));
    if (v < 0) begin
      return '0;
    end else if (v > hs) begin
      return hi;
    end
    return COORD_W'(v);
  endfunction

  logic [7:0] frame_store [STORE_BYTES];

  state_e                     state_q, state_d;
  logic                       enabled_q;
  op_e                        op_q, op_d;
  logic signed [FIELD_W-1:0]  left_q, left_d, top_q, top_d;
  logic signed [FIELD_W-1:0]  wid_q, wid_d, hgt_q, hgt_d;
  logic [7:0]                 color_q, color_d;
  logic [COORD_W-1:0]         x0_q, x0_d, x1_q, x1_d, col_q, col_d;
  logic [COORD_W-1:0]         row_q, row_d, y1_q, y1_d;
  logic [ADDR_W-1:0]          addr_q, addr_d, row_base_q, row_base_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]         out_data_q, out_data_d;
  logic                       mem_we;

  // clip stage signals
  logic signed [SUM_W-1:0]    lx, ty, ws, hs;
  logic                       op_ok;
  logic [COORD_W-1:0]         x0c, x1c, y0c, y1c;
  logic [ADDR_W-1:0]          base_c;
  logic                       go;

  always_comb begin
    op_ok = 1'b1;
    lx = SUM_W'(left_q);
    ty = SUM_W'(top_q);
    ws = SUM_W'(1);
    hs = SUM_W'(1);
    case (op_q)
      OP_PIXEL: ;
      OP_RECT: begin
        ws = SUM_W'(wid_q);
        hs = SUM_W'(hgt_q);
      end
      OP_CLEAR: begin
        lx = '0;
        ty = '0;
        ws = $signed(SUM_W'(WIDTH_C));
        hs = $signed(SUM_W'(HEIGHT_C));
      end
      default: op_ok = 1'b0;
    endcase
    x0c = clamp_c(lx, WIDTH_C);
    x1c = clamp_c(lx + ws, WIDTH_C);
    y0c = clamp_c(ty, HEIGHT_C);
    y1c = clamp_c(ty + hs, HEIGHT_C);
    base_c = ADDR_W'(ADDR_W'(y0c) * WIDTH_A) + ADDR_W'(x0c);
    go = enabled_q && op_ok && (ws > 0) && (hs > 0) && (x1c > x0c) && (y1c > y0c);
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    left_d      = left_q;
    top_d       = top_q;
    wid_d       = wid_q;
    hgt_d       = hgt_q;
    color_d     = color_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    col_d       = col_q;
    row_d       = row_q;
    y1_d        = y1_q;
    addr_d      = addr_q;
    row_base_d  = row_base_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    in_stall_o  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d    = op_e'(operation_i);
          left_d  = left_i;
          top_d   = top_i;
          wid_d   = rect_width_i;
          hgt_d   = rect_height_i;
          color_d = fill_color_i;
          state_d = ST_CLIP;
        end
      end
      ST_CLIP: begin
        x0_d       = x0c;
        x1_d       = x1c;
        col_d      = x0c;
        row_d      = y0c;
        y1_d       = y1c;
        addr_d     = base_c;
        row_base_d = base_c;
        count_d    = '0;
        state_d    = go ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        mem_we  = 1'b1;
        count_d = count_q + COUNT_W'(1);
        if (col_q + COORD_W'(1) == x1_q) begin
          if (row_q + COORD_W'(1) == y1_q) begin
            state_d = ST_DONE;
          end else begin
            row_d      = row_q + COORD_W'(1);
            col_d      = x0_q;
            row_base_d = row_base_q + WIDTH_A;
            addr_d     = row_base_q + WIDTH_A;
          end
        end else begin
          col_d  = col_q + COORD_W'(1);
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      enabled_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        enabled_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    left_q     <= left_d;
    top_q      <= top_d;
    wid_q      <= wid_d;
    hgt_q      <= hgt_d;
    color_q    <= color_d;
    x0_q       <= x0_d;
    x1_q       <= x1_d;
    col_q      <= col_d;
    row_q      <= row_d;
    y1_q       <= y1_d;
    addr_q     <= addr_d;
    row_base_q <= row_base_d;
    count_q    <= count_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_store[addr_q] <= color_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixels_written_o = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/crfe_checker.sv
// Port-level assertions for the clipped rectangle fill engine, bound to the top level.
`default_nettype none

module crfe_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_stall_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic [crfe_pkg::COUNT_W-1:0]         pixels_written_o
);
  import crfe_pkg::*;

  localparam bit COUNT_FITS = (STORE_BYTES < (1 << COUNT_W));

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixels_written_o))
    else $error("result word changed under stall");

  // an accepted command keeps the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command accepted while engine still busy");

  // a new result appears only at the end of a command
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result posted without a command in flight");

  // no command writes more bytes than the store holds
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && COUNT_FITS |-> pixels_written_o <= COUNT_W'(STORE_BYTES))
    else $error("pixel count exceeds frame store size");

endmodule

bind clipped_rect_fill_engine crfe_checker u_crfe_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the clipped rectangle fill engine.
`timescale 1ns / 1ps

module testbench;
  import crfe_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, must write nothing
  localparam int BIG_FILL = 2048;         // fills above this many pixels are rationed

  typedef struct {
    logic              en;
    logic [1:0]        op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [7:0]        color;
    int                known;  // typed-in count, -1 to use the predictor
  } fill_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic cmd_valid = 1'b0;
  logic [1:0] cmd_op = '0;
  logic signed [15:0] cmd_left = '0;
  logic signed [15:0] cmd_top = '0;
  logic signed [15:0] cmd_width = '0;
  logic signed [15:0] cmd_height = '0;
  logic [7:0] cmd_color = '0;
  logic res_stall = 1'b0;
  wire logic in_stall_o;
  wire logic out_valid_o;
  wire logic [COUNT_W-1:0] pixels_written_o;

  logic enable_shadow = 1'b0;
  logic [15:0] pending_counts[$];
  logic [15:0] popped_count;
  fill_cmd_t directed_cmds[$];
  int fail_count = 0;
  int burst_left = 0;
  int big_fills_left = 5;
  int stall_mode = 0;
  int mode_left = 0;

  clipped_rect_fill_engine u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (cmd_valid),
    .in_stall_o       (in_stall_o),
    .operation_i      (cmd_op),
    .left_i           (cmd_left),
    .top_i            (cmd_top),
    .rect_width_i     (cmd_width),
    .rect_height_i    (cmd_height),
    .fill_color_i     (cmd_color),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (res_stall),
    .pixels_written_o (pixels_written_o)
  );

  always #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("clipped_rect_fill_engine: mismatch");
    $finish;
  end

  function automatic int pick(int lo, int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic int clamp_to(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  function automatic int clipped_area(int x, int y, int w, int h);
    int x0;
    int x1;
    int y0;
    int y1;
    if (w <= 0 || h <= 0) return 0;
    x0 = clamp_to(x, SCREEN_WIDTH);
    x1 = clamp_to(x + w, SCREEN_WIDTH);
    y0 = clamp_to(y, SCREEN_HEIGHT);
    y1 = clamp_to(y + h, SCREEN_HEIGHT);
    if (x1 <= x0 || y1 <= y0) return 0;
    return (x1 - x0) * (y1 - y0);
  endfunction

  function automatic logic [15:0] pixels_covered(logic en, fill_cmd_t c);
    int n;
    n = 0;
    if (en) begin
      case (c.op)
        OP_PIXEL: n = clipped_area(c.x, c.y, 1, 1);
        OP_RECT:  n = clipped_area(c.x, c.y, c.w, c.h);
        OP_CLEAR: n = STORE_BYTES;
        default:  n = 0;
      endcase
    end
    return n[15:0];
  endfunction

  function automatic fill_cmd_t random_cmd();
    fill_cmd_t c;
    int sel;
    sel = pick(0, 99);
    c.en = 1'b1;
    c.known = -1;
    c.color = 8'($urandom);
    c.op = OP_RECT;
    c.x = 16'($urandom);
    c.y = 16'($urandom);
    c.w = 16'($urandom);
    c.h = 16'($urandom);
    if (sel < 35) begin
      c.op = OP_PIXEL;
      c.x = 16'(pick(-4, SCREEN_WIDTH + 3));
      c.y = 16'(pick(-4, SCREEN_HEIGHT + 3));
    end else if (sel < 75) begin
      c.x = 16'(pick(-40, SCREEN_WIDTH + 20));
      c.y = 16'(pick(-40, SCREEN_HEIGHT + 40));
      c.w = 16'(pick(-3, 32));
      c.h = 16'(pick(-3, 32));
    end else if (sel < 85) begin
      c.op = 2'($urandom_range(0, 3));  // noise on every field
    end else if (sel < 90) begin
      c.op = OP_NONE;
    end else if (sel < 95) begin
      c.op = OP_CLEAR;
    end else begin
      c.x = 16'(pick(-400, 100));
      c.y = 16'(pick(-400, 100));
      c.w = 16'(pick(200, 32767));
      c.h = 16'(pick(200, 32767));
    end
    // a full-screen fill takes long to write; keep only a handful
    if (pixels_covered(1'b1, c) > BIG_FILL) begin
      if (big_fills_left > 0) big_fills_left--;
      else c.op = OP_PIXEL;
    end
    return c;
  endfunction

  task automatic add_row(logic en, logic [1:0] op, int x, int y, int w, int h,
                         int color, int known);
    fill_cmd_t c;
    c.en = en;
    c.op = op;
    c.x = 16'(x);
    c.y = 16'(y);
    c.w = 16'(w);
    c.h = 16'(h);
    c.color = 8'(color);
    c.known = known;
    directed_cmds.push_back(c);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    fail_count++;
    $display("%0t %s: got %0d want %0d", $time, what, got, want);
  endtask

  // Send one command word in bursts, then log its expected count on acceptance.
  task automatic issue(fill_cmd_t c);
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat (pick(1, 8)) @(posedge clk);
      burst_left = pick(1, 12);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd_op <= c.op;
    cmd_left <= c.x;
    cmd_top <= c.y;
    cmd_width <= c.w;
    cmd_height <= c.h;
    cmd_color <= c.color;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    if (c.known >= 0) pending_counts.push_back(16'(c.known));
    else pending_counts.push_back(pixels_covered(enable_shadow, c));
  endtask

  // Drain, let the engine settle, then write the enable register.
  task automatic set_enable(logic v);
    cmd_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    enable_shadow = v;
  endtask

  // Result side stalls in modes: never, sparse, or mostly stalled.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= pick(0, 2);
        mode_left <= pick(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       res_stall <= 1'b0;
        1:       res_stall <= ($urandom_range(0, 2) == 0);
        default: res_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !res_stall) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected result word", pixels_written_o, 16'd0);
      end else begin
        popped_count = pending_counts.pop_front();
        if (pixels_written_o !== popped_count)
          report_mismatch("pixels_written", pixels_written_o, popped_count);
      end
    end
  end

  initial begin
    int n_items;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_enable(1'b0);

    //      en  op        left    top     width   height  color  count
    add_row(0, OP_CLEAR,  0,      0,      0,      0,      255,   0);
    add_row(0, OP_RECT,   0,      0,      320,    200,    0,     0);
    add_row(0, OP_PIXEL,  10,     10,     0,      0,      85,    0);
    add_row(1, OP_PIXEL,  0,      0,      -32768, 32767,  0,     1);
    add_row(1, OP_PIXEL,  319,    199,    32767,  -32768, 255,   1);
    add_row(1, OP_PIXEL,  320,    0,      1,      1,      1,     0);
    add_row(1, OP_PIXEL,  -1,     5,      1,      1,      2,     0);
    add_row(1, OP_PIXEL,  5,      200,    1,      1,      3,     0);
    add_row(1, OP_PIXEL,  -32768, -32768, 0,      0,      4,     0);
    add_row(1, OP_PIXEL,  32767,  32767,  0,      0,      5,     0);
    add_row(1, OP_NONE,   0,      0,      10,     10,     6,     0);
    add_row(1, OP_RECT,   10,     10,     0,      5,      7,     0);
    add_row(1, OP_RECT,   10,     10,     5,      -1,     8,     0);
    add_row(1, OP_RECT,   10,     10,     -32768, -32768, 9,     0);
    add_row(1, OP_RECT,   10,     20,     3,      4,      10,    12);
    add_row(1, OP_RECT,   -2,     -3,     5,      5,      11,    -1);
    add_row(1, OP_RECT,   318,    198,    10,     10,     12,    -1);
    add_row(1, OP_RECT,   -32768, -32768, 32767,  32767,  13,    0);
    add_row(1, OP_RECT,   0,      0,      32767,  32767,  14,    64000);
    add_row(1, OP_RECT,   32767,  32767,  32767,  32767,  15,    0);
    add_row(1, OP_RECT,   100,    -50,    7,      60,     16,    -1);
    add_row(1, OP_CLEAR,  12345,  -7,     -1,     -1,     165,   64000);
    add_row(1, OP_RECT,   319,    0,      1,      200,    17,    200);
    add_row(0, OP_RECT,   0,      0,      4,      4,      18,    0);
    add_row(0, OP_NONE,   0,      0,      0,      0,      19,    0);

    foreach (directed_cmds[i]) begin
      if (directed_cmds[i].en !== enable_shadow) set_enable(directed_cmds[i].en);
      issue(directed_cmds[i]);
    end

    // random phases: mostly enabled, one short disabled phase
    for (int phase = 0; phase < 4; phase++) begin
      set_enable(phase != 1);
      n_items = (phase == 1) ? 10 : 30;
      repeat (n_items) issue(random_cmd());
    end

    cmd_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("clipped_rect_fill_engine: match");
    end else begin
      $display("clipped_rect_fill_engine: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/crfe_pkg.sv
rtl/clipped_rect_fill_engine.sv
rtl/crfe_checker.sv
tb/testbench.sv
